// ===== design/sca_pkg.sv =====
package sca_pkg;

  localparam int NUM_STRIPS = 768;
  localparam int MAX_HITS   = 5;

  // input and output hit ports are fixed at five
  localparam int IN_HITS  = 5;
  localparam int OUT_HITS = 5;

  localparam int STRIP_W     = 10;
  localparam int ADC_W       = 10;
  localparam int SIGMA_W     = 12;
  localparam int WEIGHT_W    = 9;
  localparam int HIT_W       = 31;
  localparam int CNT_W       = 10;
  localparam int ADC_SUM_W   = 20;
  localparam int NOISE_SUM_W = 22;
  localparam int POS_SUM_W   = 30;
  localparam int MEAN_W      = 16;
  localparam int FRAC_W      = 6;
  localparam int DIVD_W      = POS_SUM_W + FRAC_W;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 12;
  localparam int MUL_B_W = 10;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int Q_SHIFT = 8;

  localparam int HIT_CNT_W = $clog2(MAX_HITS + 1);
  localparam int HIT_POS_W = $clog2(IN_HITS);

  localparam int EMPTY_INT = (NUM_STRIPS + 1 > 1023) ? 1023 : NUM_STRIPS + 1;
  localparam logic [STRIP_W-1:0] EMPTY_STRIP = STRIP_W'(EMPTY_INT);
  localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
  localparam logic [ADC_W-1:0]   WADC_MAX    = '1;

  typedef logic [HIT_W-1:0] hit_id_t;

endpackage

// ===== design/sca_div.sv =====
module sca_div
  import sca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIVD_W-1:0]    dividend,
  input  logic [ADC_SUM_W-1:0] divisor,
  output logic                 done,
  output logic [MEAN_W-1:0]    quotient
);

  localparam int CYC_W = $clog2(MEAN_W + 1);

  logic                 busy;
  logic [CYC_W-1:0]     cyc;
  logic [ADC_SUM_W-1:0] dvsr;
  logic [ADC_SUM_W-1:0] rem;
  logic [MEAN_W-1:0]    dlow;
  logic [ADC_SUM_W:0]   trial;
  logic                 fits;
  logic                 ovf;

  // upper dividend bits at or above the divisor mean the quotient exceeds 16 bits
  assign ovf   = dividend[DIVD_W-1:MEAN_W] >= divisor;
  assign trial = {rem, dlow[MEAN_W-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cyc  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvsr <= divisor;
        rem  <= dividend[DIVD_W-1:MEAN_W];
        dlow <= dividend[MEAN_W-1:0];
        if (divisor == '0) begin
          quotient <= '0;
          done     <= 1'b1;
        end else if (ovf) begin
          quotient <= '1;
          done     <= 1'b1;
        end else begin
          quotient <= '0;
          busy     <= 1'b1;
          cyc      <= CYC_W'(MEAN_W);
        end
      end else if (busy) begin
        rem      <= fits ? ADC_SUM_W'(trial - {1'b0, dvsr}) : trial[ADC_SUM_W-1:0];
        dlow     <= {dlow[MEAN_W-2:0], 1'b0};
        quotient <= {quotient[MEAN_W-2:0], fits};
        cyc      <= cyc - 1'b1;
        if (cyc == CYC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("divider done without a request");

endmodule

// ===== design/strip_cluster_accumulator.sv =====
// Channel  Direction  Handshake                Payload
// in       sink       in_valid / in_stall      new_cluster, strip_index, adc_value,
//                                              noise_sigma, weight, hit_id_0..4
// out      source     out_valid / out_stall    first_strip, cluster_size, total_adc,
//                                              first_adc, last_adc, total_noise,
//                                              mean_strip, out_hit_0..4
// out_valid rises after the input transfer once the multiplies, the sum update, the
// position term, the hit merge and the 16-step restoring divider for the centroid
// are done; no division runs when the ADC sum is zero or the centroid saturates.
// One multiplier is shared for weighted ADC, weighted noise and position term.
// in_stall is low only while the sequencer is idle; a result held by out_stall
// holds the sequencer in its last step. Synchronous reset clears the cluster.
module strip_cluster_accumulator
  import sca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   new_cluster,
  input  logic [STRIP_W-1:0]     strip_index,
  input  logic [ADC_W-1:0]       adc_value,
  input  logic [SIGMA_W-1:0]     noise_sigma,
  input  logic [WEIGHT_W-1:0]    weight,
  input  logic [HIT_W-1:0]       hit_id_0,
  input  logic [HIT_W-1:0]       hit_id_1,
  input  logic [HIT_W-1:0]       hit_id_2,
  input  logic [HIT_W-1:0]       hit_id_3,
  input  logic [HIT_W-1:0]       hit_id_4,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STRIP_W-1:0]     first_strip,
  output logic [CNT_W-1:0]       cluster_size,
  output logic [ADC_SUM_W-1:0]   total_adc,
  output logic [ADC_W-1:0]       first_adc,
  output logic [ADC_W-1:0]       last_adc,
  output logic [NOISE_SUM_W-1:0] total_noise,
  output logic [MEAN_W-1:0]      mean_strip,
  output logic [HIT_W-1:0]       out_hit_0,
  output logic [HIT_W-1:0]       out_hit_1,
  output logic [HIT_W-1:0]       out_hit_2,
  output logic [HIT_W-1:0]       out_hit_3,
  output logic [HIT_W-1:0]       out_hit_4
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_ADC  = 3'd1;
  localparam logic [2:0] S_MUL_NOI  = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_POSITION = 3'd4;
  localparam logic [2:0] S_DIV_GO   = 3'd5;
  localparam logic [2:0] S_DIV_WAIT = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;

  // latched strip
  logic [STRIP_W-1:0]  strip_q;
  logic [ADC_W-1:0]    adc_q;
  logic [SIGMA_W-1:0]  sigma_q;
  logic [WEIGHT_W-1:0] weight_q;
  hit_id_t             hit_in [IN_HITS];

  // cluster state
  logic [STRIP_W-1:0]     low_strip;
  logic [CNT_W-1:0]       strip_count;
  logic [ADC_SUM_W-1:0]   adc_sum;
  logic [ADC_W-1:0]       low_edge_adc;
  logic [ADC_W-1:0]       high_edge_adc;
  logic [NOISE_SUM_W-1:0] noise_sum;
  logic [POS_SUM_W-1:0]   position_sum;
  hit_id_t                hit_list [MAX_HITS];
  logic [HIT_CNT_W-1:0]   hit_cnt;
  logic [ADC_W-1:0]       wadc;
  logic [MEAN_W-1:0]      mean;

  // hit merge walker
  logic                 hit_run;
  logic [HIT_POS_W-1:0] hit_pos;
  hit_id_t              hit_cur;
  logic                 hit_dup;
  logic                 hit_full;

  // shared multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  logic                   div_start;
  logic                   div_done;
  logic [MEAN_W-1:0]      div_q;

  logic [ADC_SUM_W:0]     adc_sum_add;
  logic [NOISE_SUM_W:0]   noise_sum_add;
  logic [POS_SUM_W:0]     pos_sum_add;
  logic [STRIP_W-1:0]     low_strip_next;
  logic                   out_free;
  logic                   load_out;
  hit_id_t                hit_pad [OUT_HITS];
  hit_id_t                out_hit_q [OUT_HITS];

  assign in_stall  = state != S_IDLE;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = (state == S_DONE) && !hit_run && out_free;
  assign div_start = state == S_DIV_GO;

  always_comb begin
    case (state)
      S_MUL_ADC: begin
        mul_a = MUL_A_W'(adc_q);
        mul_b = MUL_B_W'(weight_q);
      end
      S_MUL_NOI: begin
        mul_a = sigma_q;
        mul_b = MUL_B_W'(weight_q);
      end
      default: begin
        mul_a = MUL_A_W'(strip_q);
        mul_b = MUL_B_W'(wadc);
      end
    endcase
  end

  assign adc_sum_add   = {1'b0, adc_sum} + (ADC_SUM_W + 1)'(wadc);
  assign noise_sum_add = {1'b0, noise_sum} + (NOISE_SUM_W + 1)'(prod[MUL_P_W-1:Q_SHIFT]);
  assign pos_sum_add   = {1'b0, position_sum} + (POS_SUM_W + 1)'(prod);
  assign low_strip_next = (strip_q < low_strip) ? strip_q : low_strip;

  assign hit_cur  = hit_in[hit_pos];
  assign hit_full = hit_cnt == HIT_CNT_W'(MAX_HITS);

  always_comb begin
    hit_dup = 1'b0;
    for (int c = 0; c < MAX_HITS; c++) begin
      if (hit_list[c] == hit_cur) hit_dup = 1'b1;
    end
  end

  for (genvar g = 0; g < OUT_HITS; g++) begin : g_pad
    if (g < MAX_HITS) begin : g_slot
      assign hit_pad[g] = hit_list[g];
    end else begin : g_none
      assign hit_pad[g] = '0;
    end
  end

  sca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({position_sum, FRAC_W'(0)}),
    .divisor  (adc_sum),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      hit_run       <= 1'b0;
      hit_pos       <= '0;
      hit_cnt       <= '0;
      low_strip     <= EMPTY_STRIP;
      strip_count   <= '0;
      adc_sum       <= '0;
      low_edge_adc  <= '0;
      high_edge_adc <= '0;
      noise_sum     <= '0;
      position_sum  <= '0;
      for (int k = 0; k < MAX_HITS; k++) hit_list[k] <= '0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      // merge one input id per cycle
      if (hit_run) begin
        if (hit_cur == '0 || hit_full) begin
          hit_run <= 1'b0;
        end else begin
          if (!hit_dup) begin
            for (int k = 0; k < MAX_HITS; k++) begin
              if (HIT_CNT_W'(k) == hit_cnt) hit_list[k] <= hit_cur;
            end
            hit_cnt <= hit_cnt + 1'b1;
          end
          if (hit_pos == HIT_POS_W'(IN_HITS - 1)) hit_run <= 1'b0;
          else hit_pos <= hit_pos + 1'b1;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            strip_q   <= strip_index;
            adc_q     <= adc_value;
            sigma_q   <= noise_sigma;
            weight_q  <= weight;
            hit_in[0] <= hit_id_0;
            hit_in[1] <= hit_id_1;
            hit_in[2] <= hit_id_2;
            hit_in[3] <= hit_id_3;
            hit_in[4] <= hit_id_4;
            hit_run   <= 1'b1;
            hit_pos   <= '0;
            if (new_cluster) begin
              hit_cnt       <= '0;
              low_strip     <= EMPTY_STRIP;
              strip_count   <= '0;
              adc_sum       <= '0;
              low_edge_adc  <= '0;
              high_edge_adc <= '0;
              noise_sum     <= '0;
              position_sum  <= '0;
              for (int k = 0; k < MAX_HITS; k++) hit_list[k] <= '0;
            end
            state <= S_MUL_ADC;
          end
        end
        S_MUL_ADC: state <= S_MUL_NOI;
        S_MUL_NOI: begin
          // saturate the weighted ADC to ten bits
          wadc  <= (prod[MUL_P_W-1:Q_SHIFT + ADC_W] != '0) ? WADC_MAX
                                                          : prod[Q_SHIFT +: ADC_W];
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          adc_sum   <= adc_sum_add[ADC_SUM_W] ? '1 : adc_sum_add[ADC_SUM_W-1:0];
          noise_sum <= noise_sum_add[NOISE_SUM_W] ? '1 : noise_sum_add[NOISE_SUM_W-1:0];
          if (strip_q < low_strip) begin
            low_strip    <= strip_q;
            low_edge_adc <= wadc;
          end
          if ({1'b0, strip_q} >= {1'b0, low_strip_next} + {1'b0, strip_count})
            high_edge_adc <= wadc;
          state <= S_POSITION;
        end
        S_POSITION: begin
          position_sum <= pos_sum_add[POS_SUM_W] ? '1 : pos_sum_add[POS_SUM_W-1:0];
          if (strip_count != CNT_MAX) strip_count <= strip_count + 1'b1;
          state <= S_DIV_GO;
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            mean  <= div_q;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the merge is finished and the output register is free
          if (load_out) begin
            first_strip  <= low_strip;
            cluster_size <= strip_count;
            total_adc    <= adc_sum;
            first_adc    <= low_edge_adc;
            last_adc     <= high_edge_adc;
            total_noise  <= noise_sum;
            mean_strip   <= mean;
            for (int k = 0; k < OUT_HITS; k++) out_hit_q[k] <= hit_pad[k];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_hit_0 = out_hit_q[0];
  assign out_hit_1 = out_hit_q[1];
  assign out_hit_2 = out_hit_q[2];
  assign out_hit_3 = out_hit_q[3];
  assign out_hit_4 = out_hit_q[4];

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final step");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_WAIT)
    else $error("divider finished while sequencer was not waiting");

  a_hit_fill: assert property (@(posedge clk) disable iff (rst)
    hit_cnt <= HIT_CNT_W'(MAX_HITS))
    else $error("hit list fill count beyond capacity");

  a_merge_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !hit_run)
    else $error("hit merge still running while idle");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import sca_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef hit_id_t [IN_HITS-1:0] hit_set_t;

  typedef struct packed {
    logic                 new_cluster;
    logic [STRIP_W-1:0]   strip_index;
    logic [ADC_W-1:0]     adc_value;
    logic [SIGMA_W-1:0]   noise_sigma;
    logic [WEIGHT_W-1:0]  weight;
    hit_set_t             hit_ids;
  } strip_t;

  typedef struct packed {
    logic [STRIP_W-1:0]     first_strip;
    logic [CNT_W-1:0]       cluster_size;
    logic [ADC_SUM_W-1:0]   total_adc;
    logic [ADC_W-1:0]       first_adc;
    logic [ADC_W-1:0]       last_adc;
    logic [NOISE_SUM_W-1:0] total_noise;
    logic [MEAN_W-1:0]      mean_strip;
    hit_id_t [OUT_HITS-1:0] hits;
  } cluster_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   new_cluster = 1'b0;
  logic [STRIP_W-1:0]     strip_index = '0;
  logic [ADC_W-1:0]       adc_value = '0;
  logic [SIGMA_W-1:0]     noise_sigma = '0;
  logic [WEIGHT_W-1:0]    weight = '0;
  hit_id_t                hit_id_0 = '0;
  hit_id_t                hit_id_1 = '0;
  hit_id_t                hit_id_2 = '0;
  hit_id_t                hit_id_3 = '0;
  hit_id_t                hit_id_4 = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STRIP_W-1:0]     first_strip;
  logic [CNT_W-1:0]       cluster_size;
  logic [ADC_SUM_W-1:0]   total_adc;
  logic [ADC_W-1:0]       first_adc;
  logic [ADC_W-1:0]       last_adc;
  logic [NOISE_SUM_W-1:0] total_noise;
  logic [MEAN_W-1:0]      mean_strip;
  hit_id_t                out_hit_0;
  hit_id_t                out_hit_1;
  hit_id_t                out_hit_2;
  hit_id_t                out_hit_3;
  hit_id_t                out_hit_4;

  strip_cluster_accumulator dut (.*);

  // cluster state as the block should hold it
  logic [STRIP_W-1:0]     cl_low;
  logic [CNT_W-1:0]       cl_count;
  logic [ADC_SUM_W-1:0]   cl_adc_sum;
  logic [ADC_W-1:0]       cl_low_adc;
  logic [ADC_W-1:0]       cl_high_adc;
  logic [NOISE_SUM_W-1:0] cl_noise_sum;
  logic [POS_SUM_W-1:0]   cl_pos_sum;
  hit_id_t [MAX_HITS-1:0] cl_hits;

  cluster_t    expected_clusters[$];
  int unsigned feed_gap_pct = 0;
  int unsigned drain_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned strips_sent = 0;
  int unsigned clusters_checked = 0;
  int unsigned mean_saturated = 0;
  int unsigned count_saturated = 0;
  int unsigned mismatches = 0;

  initial forever #10 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d clusters still due", cycle_count,
             expected_clusters.size());
    $display("strip_cluster_accumulator: mismatch");
    $finish;
  end

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b, int w);
    longint unsigned top;
    top = (64'd1 << w) - 1;
    return (a + b > top) ? top : a + b;
  endfunction

  function automatic void empty_cluster();
    cl_low       = EMPTY_STRIP;
    cl_count     = '0;
    cl_adc_sum   = '0;
    cl_low_adc   = '0;
    cl_high_adc  = '0;
    cl_noise_sum = '0;
    cl_pos_sum   = '0;
    cl_hits      = '0;
  endfunction

  function automatic cluster_t add_strip(strip_t s);
    longint unsigned adc, sigma, wt, idx, wadc, wnoise, lo, cnt, num, den, quot;
    int slot, b, c;
    bit stop, fresh;
    cluster_t r;
    if (s.new_cluster) empty_cluster();
    adc   = s.adc_value;
    sigma = s.noise_sigma;
    wt    = s.weight;
    idx   = s.strip_index;
    wadc  = (adc * wt) >> Q_SHIFT;
    if (wadc > WADC_MAX) wadc = WADC_MAX;
    wnoise = (sigma * wt) >> Q_SHIFT;
    cl_adc_sum   = ADC_SUM_W'(sat_sum(cl_adc_sum, wadc, ADC_SUM_W));
    cl_noise_sum = NOISE_SUM_W'(sat_sum(cl_noise_sum, wnoise, NOISE_SUM_W));
    if (idx < cl_low) begin
      cl_low     = s.strip_index;
      cl_low_adc = ADC_W'(wadc);
    end
    // upper edge is judged against the low strip after this update
    lo  = cl_low;
    cnt = cl_count;
    if (idx >= lo + cnt) cl_high_adc = ADC_W'(wadc);
    cl_pos_sum = POS_SUM_W'(sat_sum(cl_pos_sum, idx * wadc, POS_SUM_W));
    den = cl_adc_sum;
    num = cl_pos_sum;
    if (den == 0) begin
      quot = 0;
    end else begin
      quot = (num << FRAC_W) / den;
      if (quot > (64'd1 << MEAN_W) - 1) quot = (64'd1 << MEAN_W) - 1;
    end
    // merge ids from the first free slot, stop at a zero id or a full list
    slot = 0;
    while (slot < MAX_HITS && cl_hits[slot] != 0) slot++;
    stop = 1'b0;
    for (b = 0; b < IN_HITS; b++) begin
      if (!stop) begin
        if (slot >= MAX_HITS || s.hit_ids[b] == 0) begin
          stop = 1'b1;
        end else begin
          fresh = 1'b1;
          for (c = 0; c < MAX_HITS; c++)
            if (cl_hits[c] == s.hit_ids[b]) fresh = 1'b0;
          if (fresh) begin
            cl_hits[slot] = s.hit_ids[b];
            slot++;
          end
        end
      end
    end
    if (cl_count != CNT_MAX) cl_count++;
    r.first_strip  = cl_low;
    r.cluster_size = cl_count;
    r.total_adc    = cl_adc_sum;
    r.first_adc    = cl_low_adc;
    r.last_adc     = cl_high_adc;
    r.total_noise  = cl_noise_sum;
    r.mean_strip   = MEAN_W'(quot);
    for (c = 0; c < OUT_HITS; c++) r.hits[c] = (c < MAX_HITS) ? cl_hits[c] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic check_cluster();
    cluster_t got, want;
    int k;
    got.first_strip  = first_strip;
    got.cluster_size = cluster_size;
    got.total_adc    = total_adc;
    got.first_adc    = first_adc;
    got.last_adc     = last_adc;
    got.total_noise  = total_noise;
    got.mean_strip   = mean_strip;
    got.hits         = {out_hit_4, out_hit_3, out_hit_2, out_hit_1, out_hit_0};
    if (expected_clusters.size() == 0) begin
      report_mismatch("result transfer with no strip outstanding");
    end else begin
      want = expected_clusters.pop_front();
      clusters_checked++;
      if (want.mean_strip == '1) mean_saturated++;
      if (want.cluster_size == CNT_MAX) count_saturated++;
      compare_field("first_strip", got.first_strip, want.first_strip);
      compare_field("cluster_size", got.cluster_size, want.cluster_size);
      compare_field("total_adc", got.total_adc, want.total_adc);
      compare_field("first_adc", got.first_adc, want.first_adc);
      compare_field("last_adc", got.last_adc, want.last_adc);
      compare_field("total_noise", got.total_noise, want.total_noise);
      compare_field("mean_strip", got.mean_strip, want.mean_strip);
      for (k = 0; k < OUT_HITS; k++)
        compare_field($sformatf("out_hit_%0d", k), got.hits[k], want.hits[k]);
    end
  endtask

  // out_stall and out_valid read here are the values from before this edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_cluster();
    out_stall <= ($urandom_range(99) < drain_stall_pct);
  end

  task automatic send_strip(strip_t s);
    while ($urandom_range(99) < feed_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    new_cluster <= s.new_cluster;
    strip_index <= s.strip_index;
    adc_value   <= s.adc_value;
    noise_sigma <= s.noise_sigma;
    weight      <= s.weight;
    hit_id_0    <= s.hit_ids[0];
    hit_id_1    <= s.hit_ids[1];
    hit_id_2    <= s.hit_ids[2];
    hit_id_3    <= s.hit_ids[3];
    hit_id_4    <= s.hit_ids[4];
    do @(posedge clk); while (in_stall);
    expected_clusters.push_back(add_strip(s));
    strips_sent++;
  endtask

  function automatic strip_t make_strip(bit nc, int idx, int adc, int sigma, int w,
                                        hit_id_t h0, hit_id_t h1, hit_id_t h2,
                                        hit_id_t h3, hit_id_t h4);
    strip_t s;
    s.new_cluster = nc;
    s.strip_index = STRIP_W'(idx);
    s.adc_value   = ADC_W'(adc);
    s.noise_sigma = SIGMA_W'(sigma);
    s.weight      = WEIGHT_W'(w);
    s.hit_ids     = {h4, h3, h2, h1, h0};
    return s;
  endfunction

  // a few ids from a small pool so duplicates are common, a zero ends the list
  function automatic hit_set_t random_hits();
    hit_set_t ids;
    int n, b;
    ids = '0;
    n = $urandom_range(IN_HITS);
    for (b = 0; b < IN_HITS; b++) begin
      if (b < n)
        ids[b] = ($urandom_range(9) < 7) ? hit_id_t'($urandom_range(1, 12)) : hit_id_t'($urandom);
      else if (b > n && $urandom_range(4) == 0)
        ids[b] = hit_id_t'($urandom_range(1, 12));
    end
    return ids;
  endfunction

  task automatic test_directed_edges();
    // zero total, then zero weight on a full-scale strip
    send_strip(make_strip(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_strip(make_strip(0, 0, 1023, 4095, 0, 0, 0, 0, 0, 0));
    send_strip(make_strip(1, 767, 1023, 4095, 256, 31'h7FFFFFFF, 1, 2, 3, 4));
    // duplicate ids and a zero id within the strip, sent while the list is already full
    send_strip(make_strip(0, 766, 512, 2048, 128, 1, 1, 5, 0, 9));
    // overweight saturates the weighted ADC; the hit list is still full
    send_strip(make_strip(0, 768, 1023, 4095, 511, 6, 7, 8, 0, 0));
    send_strip(make_strip(0, 1023, 1, 1, 1, 9, 0, 0, 0, 0));
    // strips at or past the empty marker never become the low strip
    send_strip(make_strip(1, 769, 300, 100, 256, 0, 5, 0, 0, 0));
    send_strip(make_strip(0, 1023, 1023, 4095, 511, 2, 0, 0, 0, 0));
    send_strip(make_strip(0, 3, 700, 3000, 200, 31'h2AAAAAAA, 31'h55555555,
                          31'h2AAAAAAA, 0, 0));
    send_strip(make_strip(0, 2, 1, 0, 256, 31'h55555555, 3, 0, 0, 0));
    send_strip(make_strip(1, 512, 1023, 4095, 256, 10, 11, 12, 13, 14));
    send_strip(make_strip(0, 513, 0, 0, 256, 15, 0, 0, 0, 0));
    send_strip(make_strip(0, 511, 100, 16, 256, 10, 0, 0, 0, 0));
    send_strip(make_strip(0, 514, 200, 32, 300, 0, 0, 0, 0, 0));
    send_strip(make_strip(0, 512, 50, 4095, 256, 0, 0, 0, 0, 0));
    send_strip(make_strip(1, 1023, 0, 4095, 511, 31'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 0));
    send_strip(make_strip(1, 0, 1023, 0, 256, 1, 2, 3, 4, 5));
    send_strip(make_strip(0, 0, 1023, 0, 256, 5, 4, 3, 2, 1));
  endtask

  task automatic random_clusters(int n);
    strip_t s;
    int sent, len, idx, k, r;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      idx = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(NUM_STRIPS - 1);
      for (k = 0; k < len && sent < n; k++) begin
        // mostly clean clusters; sometimes a missing or stray new-cluster flag
        s.new_cluster = (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0);
        s.strip_index = STRIP_W'(idx);
        r = $urandom_range(9);
        s.adc_value   = (r == 0) ? '0 : (r == 1) ? '1 : ADC_W'($urandom_range(1023));
        s.noise_sigma = SIGMA_W'($urandom_range(4095));
        r = $urandom_range(9);
        s.weight      = (r < 6) ? WEIGHT_W'(256) :
                        (r < 9) ? WEIGHT_W'($urandom_range(256)) : WEIGHT_W'($urandom_range(511));
        s.hit_ids     = random_hits();
        send_strip(s);
        sent++;
        r = $urandom_range(9);
        idx = (r < 7) ? idx + 1 : (r < 9) ? idx - 1 : $urandom_range(1023);
        idx = idx & 1023;
      end
    end
  endtask

  // one long cluster of full-scale strips near the top: every sum, the count
  // and the centroid run into saturation
  task automatic saturating_cluster(int n);
    strip_t s;
    int k;
    for (k = 0; k < n; k++) begin
      s.new_cluster = (k == 0);
      s.strip_index = STRIP_W'($urandom_range(1016, 1023));
      s.adc_value   = '1;
      s.noise_sigma = SIGMA_W'($urandom_range(3900, 4095));
      s.weight      = WEIGHT_W'($urandom_range(256, 511));
      s.hit_ids     = random_hits();
      send_strip(s);
    end
  endtask

  initial begin
    empty_cluster();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    feed_gap_pct    = 19;
    drain_stall_pct = 60;
    test_directed_edges();
    random_clusters(280);

    feed_gap_pct    = 60;
    drain_stall_pct = 19;
    random_clusters(280);

    feed_gap_pct    = 0;
    drain_stall_pct = 0;
    saturating_cluster(1040);
    random_clusters(40);

    in_valid <= 1'b0;
    while (expected_clusters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d strips sent, %0d cluster results checked in %0d cycles, %0d errors",
             strips_sent, clusters_checked, cycle_count, mismatches);
    $display("results with saturated centroid: %0d, with saturated strip count: %0d",
             mean_saturated, count_saturated);
    if (mismatches == 0)
      $display("strip_cluster_accumulator: match");
    else
      $display("strip_cluster_accumulator: mismatch");
    $finish;
  end

endmodule

// ===== strip_cluster_accumulator.f =====
design/sca_pkg.sv
design/sca_div.sv
design/strip_cluster_accumulator.sv
verif/tb_top.sv
